// File: rtl/wbl_pkg.sv
package wbl_pkg;

  // grid geometry: the banked store splits rows and columns by parity,
  // so the grid point count is even
  localparam int GRID_POINTS = 64;
  localparam int IDX_W       = $clog2(GRID_POINTS);
  localparam int FRAC_W      = 16;
  localparam int VAL_W       = 32;
  localparam int WORD_W      = 3 * VAL_W;
  localparam int NUM_BANKS   = 4;
  localparam int BANK_AW     = 2 * (IDX_W - 1);
  localparam int BANK_DEPTH  = GRID_POINTS * GRID_POINTS / NUM_BANKS;
  localparam int QUEUE_DEPTH = 4;
  localparam int INTERP_LAT  = 4;
  localparam int PROD_W      = VAL_W + FRAC_W + 1;
  localparam int SUM_W       = 2 * VAL_W;

  localparam logic [VAL_W-1:0]  SIGN_BIAS = VAL_W'(1) << (VAL_W - 1);
  localparam logic [FRAC_W:0]   WEIGHT_ONE = (FRAC_W + 1)'(1) << FRAC_W;
  localparam logic [SUM_W-1:0]  ROUND_HALF = SUM_W'(1) << (VAL_W - 1);

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [FRAC_W-1:0] frac_t;
  typedef logic [VAL_W-1:0]  val_t;
  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_LOAD   = 1'b1
  } item_op_t;

  // for a load, sl/el carry the row/column and the values are offset binary
  typedef struct packed {
    item_op_t op;
    idx_t     sl;
    idx_t     sh;
    idx_t     el;
    idx_t     eh;
    frac_t    fa;
    frac_t    fb;
    val_t     curv;
    val_t     rate;
    val_t     len;
  } queue_item_t;

endpackage

// File: rtl/wrapped_bilinear_table_lookup.sv
// result path: an accepted lookup passes through the queue, a bank read and four
//   interpolation stages before its result shows with out_valid high; loads
//   produce no result
// throughput: one transaction per cycle while busy is low
// reset: synchronous active-low rst_n clears the queue and valid pipeline only;
//   the grid tables are not cleared, and the receiver cannot stall the output
module wrapped_bilinear_table_lookup import wbl_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  // input channel: a transaction is taken when start is high and busy is low
  input  logic                start,
  output logic                busy,
  input  logic                in_command,
  input  logic signed [31:0]  in_start_turns,
  input  logic signed [31:0]  in_end_turns,
  input  logic [5:0]          in_entry_row,
  input  logic [5:0]          in_entry_col,
  input  logic signed [31:0]  in_curv_entry,
  input  logic signed [31:0]  in_rate_entry,
  input  logic signed [31:0]  in_length_entry,
  // result channel: one-cycle strobe, no back-pressure
  output logic                out_valid,
  output logic signed [31:0]  out_curv_est,
  output logic signed [31:0]  out_rate_est,
  output logic signed [31:0]  out_length_est,
  output logic [31:0]         out_curv_spread,
  output logic [31:0]         out_rate_spread,
  output logic [31:0]         out_length_spread
);

  // front/back hand-off
  logic        push;
  queue_item_t push_item;
  logic        queue_full;
  logic        pop;
  logic        pop_valid;
  queue_item_t pop_item;

  // back end outputs before sign reinterpretation
  val_t        curv_est;
  val_t        rate_est;
  val_t        length_est;
  val_t        curv_spread;
  val_t        rate_spread;
  val_t        length_spread;

  // busy only when the queue is full; the back end drains one entry a cycle,
  // so in steady state it stays low and a transaction enters every cycle
  assign busy = queue_full;

  // front end: wraps both angles, splits them into grid index and fraction,
  // works out the high neighbor, and turns loads into offset-binary writes
  wbl_front u_front (
    .start           (start),
    .busy            (busy),
    .in_command      (in_command),
    .in_start_turns  (in_start_turns),
    .in_end_turns    (in_end_turns),
    .in_entry_row    (in_entry_row),
    .in_entry_col    (in_entry_col),
    .in_curv_entry   (in_curv_entry),
    .in_rate_entry   (in_rate_entry),
    .in_length_entry (in_length_entry),
    .push            (push),
    .push_item       (push_item)
  );

  // short queue between classification and table access; loads and lookups
  // stay in order, so a lookup always sees every earlier load
  wbl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .pop_valid (pop_valid),
    .pop_item  (pop_item)
  );

  // back end: four parity banks hold all three tables, read the four corners
  // together, then a pipelined bilinear blend and corner spread per table
  wbl_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .pop_valid     (pop_valid),
    .pop_item      (pop_item),
    .pop           (pop),
    .out_valid     (out_valid),
    .curv_est      (curv_est),
    .rate_est      (rate_est),
    .length_est    (length_est),
    .curv_spread   (curv_spread),
    .rate_spread   (rate_spread),
    .length_spread (length_spread)
  );

  assign out_curv_est      = $signed(curv_est);
  assign out_rate_est      = $signed(rate_est);
  assign out_length_est    = $signed(length_est);
  assign out_curv_spread   = curv_spread;
  assign out_rate_spread   = rate_spread;
  assign out_length_spread = length_spread;

endmodule

// File: rtl/wbl_front.sv
module wbl_front import wbl_pkg::*; (
  input  logic                start,
  input  logic                busy,
  input  logic                in_command,
  input  logic signed [31:0]  in_start_turns,
  input  logic signed [31:0]  in_end_turns,
  input  logic [5:0]          in_entry_row,
  input  logic [5:0]          in_entry_col,
  input  logic signed [31:0]  in_curv_entry,
  input  logic signed [31:0]  in_rate_entry,
  input  logic signed [31:0]  in_length_entry,
  output logic                push,
  output queue_item_t         push_item
);

  typedef struct packed {
    idx_t  lo;
    idx_t  hi;
    frac_t frac;
  } angle_split_t;

  function automatic angle_split_t split_angle(input frac_t u);
    logic [FRAC_W+IDX_W-1:0] p;
    logic [IDX_W:0]          h;
    angle_split_t            r;
    p      = (FRAC_W + IDX_W)'(u) * (FRAC_W + IDX_W)'(GRID_POINTS);
    r.lo   = p[FRAC_W +: IDX_W];
    r.frac = p[FRAC_W-1:0];
    h      = {1'b0, r.lo} + ((r.frac != '0) ? (IDX_W + 1)'(1) : (IDX_W + 1)'(0));
    r.hi   = (h == (IDX_W + 1)'(GRID_POINTS)) ? '0 : h[IDX_W-1:0];
    return r;
  endfunction

  angle_split_t sa;
  angle_split_t ea;
  logic         row_ok;
  logic         col_ok;
  logic         is_load;

  assign sa      = split_angle(in_start_turns[FRAC_W-1:0]);
  assign ea      = split_angle(in_end_turns[FRAC_W-1:0]);
  assign row_ok  = (32'(in_entry_row) < 32'(GRID_POINTS));
  assign col_ok  = (32'(in_entry_col) < 32'(GRID_POINTS));
  assign is_load = (in_command == 1'b1);

  // loads outside the grid are dropped here
  assign push = start && !busy && (!is_load || (row_ok && col_ok));

  always_comb begin
    push_item      = '0;
    push_item.curv = in_curv_entry ^ SIGN_BIAS;
    push_item.rate = in_rate_entry ^ SIGN_BIAS;
    push_item.len  = in_length_entry ^ SIGN_BIAS;
    if (is_load) begin
      push_item.op = OP_LOAD;
      push_item.sl = IDX_W'(in_entry_row);
      push_item.el = IDX_W'(in_entry_col);
    end else begin
      push_item.op = OP_LOOKUP;
      push_item.sl = sa.lo;
      push_item.sh = sa.hi;
      push_item.fa = sa.frac;
      push_item.el = ea.lo;
      push_item.eh = ea.hi;
      push_item.fb = ea.frac;
    end
  end

endmodule

// File: rtl/wbl_queue.sv
module wbl_queue import wbl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  queue_item_t push_item,
  output logic        full,
  input  logic        pop,
  output logic        pop_valid,
  output queue_item_t pop_item
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  queue_item_t       slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_push;
  logic              do_pop;

  assign full      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_item  = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// File: rtl/wbl_interp.sv
module wbl_interp import wbl_pkg::*; (
  input  logic  clk,
  input  val_t  x11,
  input  val_t  x21,
  input  val_t  x12,
  input  val_t  x22,
  input  frac_t fa,
  input  frac_t fb,
  output val_t  est,
  output val_t  spread
);

  // stage 1: corner weights along the start angle, pairwise min/max
  logic [FRAC_W:0]    wa;
  logic [PROD_W-1:0]  p11_r, p21_r, p12_r, p22_r;
  logic [FRAC_W:0]    wb1_r;
  logic [FRAC_W:0]    fb1_r;
  val_t               mxa_r, mna_r, mxb_r, mnb_r;
  // stage 2: sums along the start angle
  logic [PROD_W-1:0]  r1_r, r2_r;
  logic [FRAC_W:0]    wb2_r;
  logic [FRAC_W:0]    fb2_r;
  val_t               mx_r, mn_r;
  // stage 3: weights along the end angle
  logic [SUM_W-1:0]   q1_r, q2_r;
  val_t               spread3_r;
  // stage 4: final sum and rounding
  logic [SUM_W-1:0]   s_nxt;
  val_t               est_r;
  val_t               spread_r;

  assign wa = WEIGHT_ONE - {1'b0, fa};

  always_ff @(posedge clk) begin
    p11_r <= {{(FRAC_W + 1){1'b0}}, x11} * {{VAL_W{1'b0}}, wa};
    p21_r <= {{(FRAC_W + 1){1'b0}}, x21} * {{(VAL_W + 1){1'b0}}, fa};
    p12_r <= {{(FRAC_W + 1){1'b0}}, x12} * {{VAL_W{1'b0}}, wa};
    p22_r <= {{(FRAC_W + 1){1'b0}}, x22} * {{(VAL_W + 1){1'b0}}, fa};
    wb1_r <= WEIGHT_ONE - {1'b0, fb};
    fb1_r <= {1'b0, fb};
    mxa_r <= (x21 > x11) ? x21 : x11;
    mna_r <= (x21 < x11) ? x21 : x11;
    mxb_r <= (x22 > x12) ? x22 : x12;
    mnb_r <= (x22 < x12) ? x22 : x12;
  end

  always_ff @(posedge clk) begin
    r1_r  <= p11_r + p21_r;
    r2_r  <= p12_r + p22_r;
    wb2_r <= wb1_r;
    fb2_r <= fb1_r;
    mx_r  <= (mxb_r > mxa_r) ? mxb_r : mxa_r;
    mn_r  <= (mnb_r < mna_r) ? mnb_r : mna_r;
  end

  always_ff @(posedge clk) begin
    q1_r      <= {{(SUM_W - PROD_W){1'b0}}, r1_r} * {{(SUM_W - FRAC_W - 1){1'b0}}, wb2_r};
    q2_r      <= {{(SUM_W - PROD_W){1'b0}}, r2_r} * {{(SUM_W - FRAC_W - 1){1'b0}}, fb2_r};
    spread3_r <= mx_r - mn_r;
  end

  // convex combination stays below 2^64, so the rounded sum cannot wrap
  assign s_nxt = q1_r + q2_r + ROUND_HALF;

  always_ff @(posedge clk) begin
    est_r    <= s_nxt[SUM_W-1 -: VAL_W] ^ SIGN_BIAS;
    spread_r <= spread3_r;
  end

  assign est    = est_r;
  assign spread = spread_r;

endmodule

// File: rtl/wbl_back.sv
module wbl_back import wbl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        pop_valid,
  input  queue_item_t pop_item,
  output logic        pop,
  output logic        out_valid,
  output val_t        curv_est,
  output val_t        rate_est,
  output val_t        length_est,
  output val_t        curv_spread,
  output val_t        rate_spread,
  output val_t        length_spread
);

  function automatic word_t pick(input logic [1:0] sel, input word_t w0, input word_t w1,
                                 input word_t w2, input word_t w3);
    word_t r;
    case (sel)
      2'd0:    r = w0;
      2'd1:    r = w1;
      2'd2:    r = w2;
      default: r = w3;
    endcase
    return r;
  endfunction

  logic                  is_lookup;
  logic                  is_load;
  logic [BANK_AW-1:0]    wr_addr;
  logic [1:0]            wr_bank;
  word_t                 wr_data;
  word_t                 rd_r [NUM_BANKS];
  logic                  rd_v_r;
  frac_t                 fa_r, fb_r;
  logic [1:0]            sel11_r, sel21_r, sel12_r, sel22_r;
  logic [INTERP_LAT-1:0] vpipe_r;
  word_t                 x11, x21, x12, x22;

  // the back end never stalls: one queue entry leaves every cycle while any is waiting
  assign pop       = pop_valid;
  assign is_lookup = pop_valid && (pop_item.op == OP_LOOKUP);
  assign is_load   = pop_valid && (pop_item.op == OP_LOAD);
  assign wr_bank   = {pop_item.sl[0], pop_item.el[0]};
  assign wr_addr   = {pop_item.sl[IDX_W-1:1], pop_item.el[IDX_W-1:1]};
  assign wr_data   = {pop_item.curv, pop_item.rate, pop_item.len};

  // four banks by row and column parity: the four corners always land in
  // distinct banks, or share one address when a fraction is zero
  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    localparam logic RP = 1'((b >> 1) & 1);
    localparam logic CP = 1'(b & 1);
    word_t              mem [BANK_DEPTH];
    idx_t               row_sel;
    idx_t               col_sel;
    logic [BANK_AW-1:0] rd_addr;
    logic               we;

    assign row_sel = (pop_item.sl[0] == RP) ? pop_item.sl : pop_item.sh;
    assign col_sel = (pop_item.el[0] == CP) ? pop_item.el : pop_item.eh;
    assign rd_addr = {row_sel[IDX_W-1:1], col_sel[IDX_W-1:1]};
    assign we      = is_load && (wr_bank == 2'(b));

    always_ff @(posedge clk) begin
      if (we) begin
        mem[wr_addr] <= wr_data;
      end
      if (is_lookup) begin
        rd_r[b] <= mem[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    fa_r    <= pop_item.fa;
    fb_r    <= pop_item.fb;
    sel11_r <= {pop_item.sl[0], pop_item.el[0]};
    sel21_r <= {pop_item.sh[0], pop_item.el[0]};
    sel12_r <= {pop_item.sl[0], pop_item.eh[0]};
    sel22_r <= {pop_item.sh[0], pop_item.eh[0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r  <= 1'b0;
      vpipe_r <= '0;
    end else begin
      rd_v_r  <= is_lookup;
      vpipe_r <= {vpipe_r[INTERP_LAT-2:0], rd_v_r};
    end
  end

  assign x11 = pick(sel11_r, rd_r[0], rd_r[1], rd_r[2], rd_r[3]);
  assign x21 = pick(sel21_r, rd_r[0], rd_r[1], rd_r[2], rd_r[3]);
  assign x12 = pick(sel12_r, rd_r[0], rd_r[1], rd_r[2], rd_r[3]);
  assign x22 = pick(sel22_r, rd_r[0], rd_r[1], rd_r[2], rd_r[3]);

  wbl_interp u_curv (
    .clk    (clk),
    .x11    (x11[3*VAL_W-1 -: VAL_W]),
    .x21    (x21[3*VAL_W-1 -: VAL_W]),
    .x12    (x12[3*VAL_W-1 -: VAL_W]),
    .x22    (x22[3*VAL_W-1 -: VAL_W]),
    .fa     (fa_r),
    .fb     (fb_r),
    .est    (curv_est),
    .spread (curv_spread)
  );

  wbl_interp u_rate (
    .clk    (clk),
    .x11    (x11[2*VAL_W-1 -: VAL_W]),
    .x21    (x21[2*VAL_W-1 -: VAL_W]),
    .x12    (x12[2*VAL_W-1 -: VAL_W]),
    .x22    (x22[2*VAL_W-1 -: VAL_W]),
    .fa     (fa_r),
    .fb     (fb_r),
    .est    (rate_est),
    .spread (rate_spread)
  );

  wbl_interp u_len (
    .clk    (clk),
    .x11    (x11[VAL_W-1:0]),
    .x21    (x21[VAL_W-1:0]),
    .x12    (x12[VAL_W-1:0]),
    .x22    (x22[VAL_W-1:0]),
    .fa     (fa_r),
    .fb     (fb_r),
    .est    (length_est),
    .spread (length_spread)
  );

  assign out_valid = vpipe_r[INTERP_LAT-1];

endmodule

// File: test/tb_top.sv
module tb_top;
  import wbl_pkg::*;

  // run limits: the cycle limit leaves a wide margin for about 970
  // transactions with up to 60 percent sender gaps
  localparam int CYCLE_LIMIT  = 100000;
  localparam int RANDOM_ITEMS = 950;
  localparam int DRAIN_CYCLES = 4 * (QUEUE_DEPTH + INTERP_LAT + 2);
  localparam int GRID_ENTRIES = GRID_POINTS * GRID_POINTS;

  // one lookup result, field for field as on the result ports
  typedef struct {
    val_t curv_est;
    val_t rate_est;
    val_t length_est;
    val_t curv_spread;
    val_t rate_spread;
    val_t length_spread;
  } lookup_result_t;

  // one input transaction, with an optional hand-written result
  typedef struct {
    item_op_t       op;
    val_t           start_turns;
    val_t           end_turns;
    idx_t           row;
    idx_t           col;
    val_t           curv;
    val_t           rate;
    val_t           len;
    bit             typed;
    lookup_result_t want;
  } stim_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic               in_command;
  logic signed [31:0] in_start_turns;
  logic signed [31:0] in_end_turns;
  logic [5:0]         in_entry_row;
  logic [5:0]         in_entry_col;
  logic signed [31:0] in_curv_entry;
  logic signed [31:0] in_rate_entry;
  logic signed [31:0] in_length_entry;
  logic               out_valid;
  logic signed [31:0] out_curv_est;
  logic signed [31:0] out_rate_est;
  logic signed [31:0] out_length_est;
  logic [31:0]        out_curv_spread;
  logic [31:0]        out_rate_spread;
  logic [31:0]        out_length_spread;

  // shadow copy of the three grid tables, kept as plain signed values
  val_t grid_curv [GRID_ENTRIES];
  val_t grid_rate [GRID_ENTRIES];
  val_t grid_len  [GRID_ENTRIES];
  // entries loaded since reset; lookups only ever touch these
  bit   loaded    [GRID_ENTRIES];

  lookup_result_t pending_results[$];
  stim_t          directed_rows[$];
  int             error_count = 0;
  int             cycle_count = 0;
  int             idle_pct    = 0;

  wrapped_bilinear_table_lookup dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_start_turns   (in_start_turns),
    .in_end_turns     (in_end_turns),
    .in_entry_row     (in_entry_row),
    .in_entry_col     (in_entry_col),
    .in_curv_entry    (in_curv_entry),
    .in_rate_entry    (in_rate_entry),
    .in_length_entry  (in_length_entry),
    .out_valid        (out_valid),
    .out_curv_est     (out_curv_est),
    .out_rate_est     (out_rate_est),
    .out_length_est   (out_length_est),
    .out_curv_spread  (out_curv_spread),
    .out_rate_spread  (out_rate_spread),
    .out_length_spread(out_length_spread)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog: a hung handshake or a lost result ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // append helpers for the result queue and the directed table
  function automatic void queue_result(input lookup_result_t r);
    pending_results.insert(pending_results.size(), r);
  endfunction

  function automatic void add_row(input stim_t s);
    directed_rows.insert(directed_rows.size(), s);
  endfunction

  // angle split: low 16 bits are the position within one turn, scaled by the
  // grid size; the high index steps one cell on, wrapping past the last row,
  // and stays on the low index when the angle sits exactly on a grid line
  function automatic void split_turns(input val_t turns, output idx_t lo, output idx_t hi,
                                      output frac_t frac);
    logic [31:0] scaled;
    scaled = 32'(turns[FRAC_W-1:0]) * GRID_POINTS;
    lo     = idx_t'(scaled >> FRAC_W);
    frac   = scaled[FRAC_W-1:0];
    if (frac == '0)
      hi = lo;
    else if (int'(lo) == GRID_POINTS - 1)
      hi = '0;
    else
      hi = lo + 1'b1;
  endfunction

  // exact bilinear blend of four signed corners, rounded half up, plus the
  // spread of the corners as an unsigned difference
  function automatic void blend(input val_t x11, input val_t x21, input val_t x12,
                                input val_t x22, input frac_t fa, input frac_t fb,
                                output val_t est, output val_t spread);
    logic signed [65:0] wa, wb, sa, sb, acc;
    logic signed [31:0] corner [4];
    logic signed [31:0] top, bottom;
    sa  = $signed({50'b0, fa});
    sb  = $signed({50'b0, fb});
    wa  = 66'sd65536 - sa;
    wb  = 66'sd65536 - sb;
    acc = ($signed(x11) * wa + $signed(x21) * sa) * wb
        + ($signed(x12) * wa + $signed(x22) * sa) * sb;
    acc = acc + 66'sd2147483648;
    est = val_t'(acc >>> 32);
    corner[0] = x11;
    corner[1] = x21;
    corner[2] = x12;
    corner[3] = x22;
    top    = corner[0];
    bottom = corner[0];
    for (int i = 1; i < 4; i++) begin
      if (corner[i] > top) top = corner[i];
      if (corner[i] < bottom) bottom = corner[i];
    end
    spread = top - bottom;
  endfunction

  // result of a lookup against the current shadow tables
  function automatic lookup_result_t predict_lookup(input val_t start_turns,
                                                    input val_t end_turns);
    idx_t           sl, sh, el, eh;
    frac_t          fa, fb;
    int             i11, i21, i12, i22;
    lookup_result_t r;
    split_turns(start_turns, sl, sh, fa);
    split_turns(end_turns, el, eh, fb);
    i11 = int'(sl) * GRID_POINTS + int'(el);
    i21 = int'(sh) * GRID_POINTS + int'(el);
    i12 = int'(sl) * GRID_POINTS + int'(eh);
    i22 = int'(sh) * GRID_POINTS + int'(eh);
    blend(grid_curv[i11], grid_curv[i21], grid_curv[i12], grid_curv[i22], fa, fb,
          r.curv_est, r.curv_spread);
    blend(grid_rate[i11], grid_rate[i21], grid_rate[i12], grid_rate[i22], fa, fb,
          r.rate_est, r.rate_spread);
    blend(grid_len[i11], grid_len[i21], grid_len[i12], grid_len[i22], fa, fb,
          r.length_est, r.length_spread);
    return r;
  endfunction

  // table values: extremes now and then, small numbers near zero, else anything
  function automatic val_t rand_value();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      4: return val_t'($urandom_range(0, 32'h3_FFFF)) - 32'h2_0000;
      default: return $urandom;
    endcase
  endfunction

  // angles: full 32 bits, biased toward grid lines and the wrapping last cell
  function automatic val_t rand_turns();
    val_t t;
    t = $urandom;
    case ($urandom_range(0, 7))
      0: t[9:0] = '0;
      1: t[15:10] = '1;
      2: t[15:0] = 16'hFFFF;
      3: t[15:0] = 16'h0000;
      default: ;
    endcase
    return t;
  endfunction

  // loads carry noise on the angle ports, lookups on the entry ports
  function automatic stim_t make_load(input idx_t row, input idx_t col, input val_t curv,
                                      input val_t rate, input val_t len);
    stim_t s;
    s.op          = OP_LOAD;
    s.start_turns = $urandom;
    s.end_turns   = $urandom;
    s.row         = row;
    s.col         = col;
    s.curv        = curv;
    s.rate        = rate;
    s.len         = len;
    s.typed       = 1'b0;
    s.want        = '{default: '0};
    return s;
  endfunction

  function automatic stim_t make_look(input val_t start_turns, input val_t end_turns);
    stim_t s;
    s.op          = OP_LOOKUP;
    s.start_turns = start_turns;
    s.end_turns   = end_turns;
    s.row         = idx_t'($urandom);
    s.col         = idx_t'($urandom);
    s.curv        = $urandom;
    s.rate        = $urandom;
    s.len         = $urandom;
    s.typed       = 1'b0;
    s.want        = '{default: '0};
    return s;
  endfunction

  function automatic stim_t make_look_typed(input val_t start_turns, input val_t end_turns,
                                            input val_t ce, input val_t re, input val_t le,
                                            input val_t cs, input val_t rs, input val_t ls);
    stim_t s;
    s       = make_look(start_turns, end_turns);
    s.typed = 1'b1;
    s.want  = '{ce, re, le, cs, rs, ls};
    return s;
  endfunction

  // drive one transaction, wait for it to be taken, then update the shadow
  // tables or queue the result it will produce
  task automatic send_item(input stim_t s);
    int idx;
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start           <= 1'b1;
    in_command      <= s.op;
    in_start_turns  <= s.start_turns;
    in_end_turns    <= s.end_turns;
    in_entry_row    <= s.row;
    in_entry_col    <= s.col;
    in_curv_entry   <= s.curv;
    in_rate_entry   <= s.rate;
    in_length_entry <= s.len;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    if (s.op == OP_LOAD) begin
      idx            = int'(s.row) * GRID_POINTS + int'(s.col);
      grid_curv[idx] = s.curv;
      grid_rate[idx] = s.rate;
      grid_len[idx]  = s.len;
      loaded[idx]    = 1'b1;
    end else if (s.typed) begin
      queue_result(s.want);
    end else begin
      queue_result(predict_lookup(s.start_turns, s.end_turns));
    end
  endtask

  // a lookup preceded by loads of whichever of its corners are still empty
  task automatic look_with_fill(input val_t start_turns, input val_t end_turns,
                                inout int count);
    idx_t  sl, sh, el, eh;
    frac_t fa, fb;
    int    corner [4];
    split_turns(start_turns, sl, sh, fa);
    split_turns(end_turns, el, eh, fb);
    corner[0] = int'(sl) * GRID_POINTS + int'(el);
    corner[1] = int'(sh) * GRID_POINTS + int'(el);
    corner[2] = int'(sl) * GRID_POINTS + int'(eh);
    corner[3] = int'(sh) * GRID_POINTS + int'(eh);
    for (int i = 0; i < 4; i++) begin
      if (!loaded[corner[i]]) begin
        send_item(make_load(idx_t'(corner[i] / GRID_POINTS), idx_t'(corner[i] % GRID_POINTS),
                            rand_value(), rand_value(), rand_value()));
        count++;
      end
    end
    send_item(make_look(start_turns, end_turns));
    count++;
  endtask

  function automatic void check_field(input string name, input val_t want_v,
                                      input val_t got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want_v, got_v);
      error_count++;
    end
  endfunction

  // result monitor: every strobe must match the oldest pending lookup
  always @(posedge clk) begin
    lookup_result_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with no lookup pending, curv_est %h", $time, out_curv_est);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("curv_est", want.curv_est, out_curv_est);
        check_field("rate_est", want.rate_est, out_rate_est);
        check_field("length_est", want.length_est, out_length_est);
        check_field("curv_spread", want.curv_spread, out_curv_spread);
        check_field("rate_spread", want.rate_spread, out_rate_spread);
        check_field("length_spread", want.length_spread, out_length_spread);
      end
    end
  end

  initial begin
    int    random_items;
    int    phase_pct [4];
    random_items = 0;
    // sender gap percentages per quarter of the random part; the receiver
    // has no back-pressure so only the sender side idles
    phase_pct[0] = 0;
    phase_pct[1] = 60;
    phase_pct[2] = 0;
    phase_pct[3] = 16;

    rst_n           <= 1'b0;
    start           <= 1'b0;
    in_command      <= OP_LOOKUP;
    in_start_turns  <= '0;
    in_end_turns    <= '0;
    in_entry_row    <= '0;
    in_entry_col    <= '0;
    in_curv_entry   <= '0;
    in_rate_entry   <= '0;
    in_length_entry <= '0;

    // directed rows: single-corner reads and one two-corner read have their
    // results typed in, the rest go through the predictor
    // corner 0,0 holds the value extremes
    add_row(make_load(6'd0, 6'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000));
    // exactly on a grid line: all four corners are the same entry
    add_row(make_look_typed(32'h0000_0000, 32'h0000_0000,
      32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'h0, 32'h0, 32'h0));
    // whole turns and upper bits wrap away, negative angles too
    add_row(make_look_typed(32'h0001_0000, 32'hFFFF_0000,
      32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'h0, 32'h0, 32'h0));
    add_row(make_look_typed(32'h7FFF_0000, 32'h8000_0000,
      32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'h0, 32'h0, 32'h0));
    // last grid point on both axes
    add_row(make_load(6'd63, 6'd63, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
    add_row(make_look_typed(32'h0000_FC00, 32'hFFFF_FC00,
      32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0));
    // fill the corners of the wrapping cell
    add_row(make_load(6'd63, 6'd0, 32'h1234_5678, 32'hEDCB_A987, 32'h0000_0000));
    add_row(make_load(6'd0, 6'd63, 32'hFFFF_FFFF, 32'h0000_0001, 32'h5555_5555));
    // half way across the wrapping cell, then the largest fraction
    add_row(make_look(32'h0000_FE00, 32'h0000_FE00));
    add_row(make_look(32'hFFFF_FFFF, 32'h8000_FFFF));
    // half way between two opposite extremes: -0.5 rounds up to zero,
    // spread covers the full unsigned range
    add_row(make_load(6'd0, 6'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0001));
    add_row(make_look_typed(32'h0000_0000, 32'h0000_0200,
      32'h0000_0000, 32'h0000_0000, 32'h0001_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
      32'h0000_0001));
    add_row(make_load(6'd63, 6'd1, 32'hAAAA_AAAA, 32'h5555_5555, 32'h7FFF_FFFF));
    // smallest nonzero fraction on both axes, start wrapping to row 0
    add_row(make_look(32'h0000_FC01, 32'h0000_0001));
    // overwrite right before a lookup that reads it
    add_row(make_load(6'd0, 6'd0, 32'h0000_0000, 32'h0000_0000, 32'h8000_0000));
    add_row(make_look(32'h8000_FFC0, 32'h0000_0010));
    add_row(make_look_typed(32'h0000_0000, 32'h0000_FC00,
      32'hFFFF_FFFF, 32'h0000_0001, 32'h5555_5555, 32'h0, 32'h0, 32'h0));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_pct = 0;
    foreach (directed_rows[i]) send_item(directed_rows[i]);

    // random part: mostly lookups whose empty corners get loaded first,
    // with stray loads anywhere in the grid as noise
    while (random_items < RANDOM_ITEMS) begin
      idle_pct = phase_pct[random_items * 4 / RANDOM_ITEMS];
      if ($urandom_range(0, 99) < 15) begin
        send_item(make_load(idx_t'($urandom_range(0, GRID_POINTS - 1)),
                            idx_t'($urandom_range(0, GRID_POINTS - 1)),
                            rand_value(), rand_value(), rand_value()));
        random_items++;
      end else begin
        look_with_fill(rand_turns(), rand_turns(), random_items);
      end
    end
    start <= 1'b0;

    // drain: all lookups answered, then a quiet spell for stray strobes
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
